// ===== rtl/ira_pkg.sv =====
// Shared types, codes and constants of the interrupt route allocator.
`default_nettype none
package ira_pkg;

    localparam int GSI_SLOTS_DEF  = 256;
    localparam int CTRL_SLOTS_DEF = 8;
    localparam int LEGACY_LINES   = 16;
    localparam int LEG_W          = $clog2(LEGACY_LINES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int SCAN_W         = 32;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int TUSER_W   = 3;

    // override mode: polarity in bits 1:0, trigger in bits 3:2
    localparam logic [1:0] POL_ACT_LOW  = 2'b11;
    localparam logic [1:0] POL_ACT_HIGH = 2'b01;
    localparam logic [1:0] TRIG_EDGE    = 2'b01;
    localparam logic [1:0] TRIG_LEVEL   = 2'b11;

    localparam logic [9:0] REG_SEL_BASE = 10'h010;

    typedef enum logic [2:0] {
        ACT_ALLOC      = 3'd0,
        ACT_FREE       = 3'd1,
        ACT_ADD_OVR    = 3'd2,
        ACT_ADD_CTRL   = 3'd3,
        ACT_MAP_GSI    = 3'd4,
        ACT_MAP_LEGACY = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_NO_FREE = 3'd1,
        STS_NO_CTRL = 3'd2,
        STS_FULL    = 3'd3,
        STS_BAD_SRC = 3'd4
    } t_status;

    // operation as classified by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ALLOC,
        OP_FREE,
        OP_OVR,
        OP_BAD_SRC,
        OP_CTRL,
        OP_MAP_GSI,
        OP_MAP_LEGACY
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_LOOKUP,
        BK_MATCH,
        BK_PICK,
        BK_COMMIT
    } t_back_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] gsi;
        logic [7:0] src;
        logic       legacy;   // src names a legacy line
        logic [3:0] flags;
        logic [7:0] base;
        logic [8:0] count;
        logic [7:0] lapic;
        logic       pol;
        logic       trig;
        logic [7:0] vector;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [7:0]  gsi_out;
        logic [2:0]  controller;
        logic [9:0]  reg_select;
        logic [15:0] entry_low;
        logic [31:0] entry_high;
    } t_result;

    // register select of a pin's low redirection word
    function automatic logic [9:0] reg_sel(input logic [7:0] pin);
        return REG_SEL_BASE + {1'b0, pin, 1'b0};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ira_front.sv =====
// Front end: unpacks input transactions and classifies them into commands.
`default_nettype none
module ira_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [ira_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [ira_pkg::TUSER_W-1:0]   i_s_tuser,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output ira_pkg::t_cmd                      o_cmd
);
    import ira_pkg::*;

    logic src_legacy;
    logic r_seen;   // a transaction was taken since reset

    assign src_legacy = i_s_tdata[15:8] < 8'(LEGACY_LINES);
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_cmd.gsi    = i_s_tdata[7:0];
        o_cmd.src    = i_s_tdata[15:8];
        o_cmd.legacy = src_legacy;
        o_cmd.flags  = i_s_tdata[19:16];
        o_cmd.base   = i_s_tdata[27:20];
        o_cmd.count  = i_s_tdata[36:28];
        o_cmd.lapic  = i_s_tdata[44:37];
        o_cmd.pol    = i_s_tdata[45];
        o_cmd.trig   = i_s_tdata[46];
        o_cmd.vector = i_s_tdata[54:47];
        case (t_action'(i_s_tuser))
            ACT_ALLOC:      o_cmd.op = OP_ALLOC;
            ACT_FREE:       o_cmd.op = OP_FREE;
            ACT_ADD_OVR:    o_cmd.op = src_legacy ? OP_OVR : OP_BAD_SRC;
            ACT_ADD_CTRL:   o_cmd.op = OP_CTRL;
            ACT_MAP_GSI:    o_cmd.op = OP_MAP_GSI;
            ACT_MAP_LEGACY: o_cmd.op = OP_MAP_LEGACY;
            default:        o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_push) begin
            r_seen <= 1'b1;
        end
    end

    // once traffic has started the queue must never be overrun
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen && i_q_full) |-> !o_push)
        else $error("front pushed into a full queue");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready != i_q_full)
        else $error("ready out of step with queue space");

    a_bad_src_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.op == OP_OVR) |-> o_cmd.legacy)
        else $error("override accepted for a non-legacy source");

endmodule
`default_nettype wire

// ===== rtl/ira_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none
module ira_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ira_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ira_pkg::t_cmd      o_head
);
    import ira_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ira_back.sv =====
// Back end: bitmap search, override table, controller match and result register.
`default_nettype none
module ira_back #(
    parameter int GSI_SLOTS  = ira_pkg::GSI_SLOTS_DEF,
    parameter int CTRL_SLOTS = ira_pkg::CTRL_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire ira_pkg::t_cmd i_q_head,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output ira_pkg::t_result   o_res
);
    import ira_pkg::*;

    localparam int GSI_W   = $clog2(GSI_SLOTS);
    localparam int NCHUNK  = (GSI_SLOTS + SCAN_W - 1) / SCAN_W;
    localparam int CHK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = NCHUNK * SCAN_W;
    localparam int SCAN_LG = $clog2(SCAN_W);
    localparam int CIDX_W  = (CTRL_SLOTS > 1) ? $clog2(CTRL_SLOTS) : 1;
    localparam int TOT_W   = $clog2(CTRL_SLOTS + 1);

    t_back_state r_state, n_state;

    // stored state
    logic [GSI_SLOTS-1:0] r_used;
    logic [7:0]           r_dest [LEGACY_LINES];
    logic [3:0]           r_mode [LEGACY_LINES];
    logic [7:0]           r_base [CTRL_SLOTS];
    logic [8:0]           r_pins [CTRL_SLOTS];
    logic [TOT_W-1:0]     r_total;

    // working registers
    t_cmd                 r_cmd, n_cmd;
    logic [7:0]           r_gsi, n_gsi;
    logic                 r_pol, n_pol;
    logic                 r_trig, n_trig;
    logic                 r_found, n_found;
    logic [CHK_W-1:0]     r_chunk, n_chunk;
    logic [CTRL_SLOTS-1:0] r_hit, n_hit;
    logic [CIDX_W-1:0]    r_cidx, n_cidx;
    logic [9:0]           r_rsel, n_rsel;
    logic                 r_m_valid, n_m_valid;
    t_result              r_res, n_res;

    // write strobes
    logic                 used_we;
    logic                 used_val;
    logic [GSI_W-1:0]     used_idx;
    logic                 ovr_we;
    logic                 ctrl_we;

    // combinational helpers
    logic [PAD_W-1:0]     padded;
    logic [SCAN_W-1:0]    chunk;
    logic                 scan_hit;
    logic [SCAN_LG-1:0]   scan_pos;
    logic [CTRL_SLOTS-1:0] hit;
    logic [CIDX_W-1:0]    pick;
    logic                 out_free;
    logic [LEG_W-1:0]     leg_idx;
    logic [3:0]           leg_mode;

    assign out_free     = !r_m_valid || i_m_tready;
    assign leg_idx      = r_cmd.src[LEG_W-1:0];
    assign leg_mode     = r_mode[leg_idx];
    assign o_m_tvalid   = r_m_valid;
    assign o_res        = r_res;

    // bitmap padded with busy slots up to whole scan words
    always_comb begin
        padded                = '1;
        padded[GSI_SLOTS-1:0] = r_used;
        chunk                 = padded[r_chunk * SCAN_W +: SCAN_W];
        scan_hit              = 1'b0;
        scan_pos              = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (!chunk[j]) begin
                scan_hit = 1'b1;
                scan_pos = SCAN_LG'(j);
            end
        end
    end

    // range compare against every live controller, then first match
    always_comb begin
        for (int i = 0; i < CTRL_SLOTS; i++) begin
            hit[i] = (TOT_W'(i) < r_total)
                  && (r_gsi >= r_base[i])
                  && ({2'b0, r_gsi} < ({2'b0, r_base[i]} + {1'b0, r_pins[i]}));
        end
        pick = '0;
        for (int i = CTRL_SLOTS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                pick = CIDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_gsi     = r_gsi;
        n_pol     = r_pol;
        n_trig    = r_trig;
        n_found   = r_found;
        n_chunk   = r_chunk;
        n_hit     = r_hit;
        n_cidx    = r_cidx;
        n_rsel    = r_rsel;
        n_m_valid = r_m_valid && !i_m_tready;
        n_res     = r_res;
        o_pop     = 1'b0;
        used_we   = 1'b0;
        used_val  = 1'b0;
        used_idx  = r_gsi[GSI_W-1:0];
        ovr_we    = 1'b0;
        ctrl_we   = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_head;
                    n_chunk = '0;
                    case (i_q_head.op)
                        OP_ALLOC:      n_state = BK_SCAN;
                        OP_MAP_GSI:    n_state = BK_LOOKUP;
                        OP_MAP_LEGACY: n_state = BK_LOOKUP;
                        default:       n_state = BK_COMMIT;
                    endcase
                end
            end
            BK_SCAN: begin
                if (scan_hit) begin
                    n_found = 1'b1;
                    n_gsi   = 8'({r_chunk, scan_pos});
                    n_state = BK_COMMIT;
                end else if (r_chunk == CHK_W'(NCHUNK - 1)) begin
                    n_found = 1'b0;
                    n_state = BK_COMMIT;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            BK_LOOKUP: begin
                n_pol  = r_cmd.pol;
                n_trig = r_cmd.trig;
                n_gsi  = (r_cmd.op == OP_MAP_GSI) ? r_cmd.gsi : r_cmd.src;
                if (r_cmd.op == OP_MAP_LEGACY && r_cmd.legacy) begin
                    n_gsi = r_dest[leg_idx];
                    if (leg_mode[1:0] == POL_ACT_LOW) begin
                        n_pol = 1'b1;
                    end else if (leg_mode[1:0] == POL_ACT_HIGH) begin
                        n_pol = 1'b0;
                    end
                    if (leg_mode[3:2] == TRIG_EDGE) begin
                        n_trig = 1'b0;
                    end else if (leg_mode[3:2] == TRIG_LEVEL) begin
                        n_trig = 1'b1;
                    end
                end
                n_state = BK_MATCH;
            end
            BK_MATCH: begin
                n_hit   = hit;
                n_state = BK_PICK;
            end
            BK_PICK: begin
                n_found = |r_hit;
                n_cidx  = pick;
                n_rsel  = reg_sel(r_gsi - r_base[pick]);
                n_state = BK_COMMIT;
            end
            BK_COMMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = BK_IDLE;
                    n_res     = '0;
                    case (r_cmd.op)
                        OP_ALLOC: begin
                            if (r_found) begin
                                n_res.gsi_out = r_gsi;
                                used_we       = 1'b1;
                                used_val      = 1'b1;
                            end else begin
                                n_res.status = STS_NO_FREE;
                            end
                        end
                        OP_FREE: begin
                            n_res.gsi_out = r_cmd.gsi;
                            used_idx      = r_cmd.gsi[GSI_W-1:0];
                            used_we       = {1'b0, r_cmd.gsi} < 9'(GSI_SLOTS);
                        end
                        OP_OVR: begin
                            n_res.gsi_out = r_cmd.gsi;
                            ovr_we        = 1'b1;
                            used_idx      = r_cmd.gsi[GSI_W-1:0];
                            used_val      = 1'b1;
                            used_we       = {1'b0, r_cmd.gsi} < 9'(GSI_SLOTS);
                        end
                        OP_BAD_SRC: begin
                            n_res.status = STS_BAD_SRC;
                        end
                        OP_CTRL: begin
                            if (r_total >= TOT_W'(CTRL_SLOTS)) begin
                                n_res.status = STS_FULL;
                            end else begin
                                n_res.controller = 3'(r_total);
                                ctrl_we          = 1'b1;
                            end
                        end
                        OP_MAP_GSI, OP_MAP_LEGACY: begin
                            n_res.gsi_out = r_gsi;
                            if (r_found) begin
                                n_res.controller = 3'(r_cidx);
                                n_res.reg_select = r_rsel;
                                n_res.entry_low  = {r_trig, 1'b0, r_pol, 5'b0, r_cmd.vector};
                                n_res.entry_high = {r_cmd.lapic, 24'b0};
                            end else begin
                                n_res.status = STS_NO_CTRL;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_used    <= '0;
            r_total   <= '0;
            for (int i = 0; i < LEGACY_LINES; i++) begin
                r_dest[i] <= 8'(i);
                r_mode[i] <= '0;
            end
        end else begin
            r_m_valid <= n_m_valid;
            if (used_we) begin
                r_used[used_idx] <= used_val;
            end
            if (ovr_we) begin
                r_dest[leg_idx] <= r_cmd.gsi;
                r_mode[leg_idx] <= r_cmd.flags;
            end
            if (ctrl_we) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // controller slots are read only below r_total, so no reset is needed
    always_ff @(posedge i_clk) begin
        if (ctrl_we) begin
            r_base[r_total[CIDX_W-1:0]] <= r_cmd.base;
            r_pins[r_total[CIDX_W-1:0]] <= r_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_gsi   <= n_gsi;
        r_pol   <= n_pol;
        r_trig  <= n_trig;
        r_found <= n_found;
        r_chunk <= n_chunk;
        r_hit   <= n_hit;
        r_cidx  <= n_cidx;
        r_rsel  <= n_rsel;
        r_res   <= n_res;
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(CTRL_SLOTS))
        else $error("controller count past table size");

    a_alloc_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_COMMIT && r_cmd.op == OP_ALLOC && r_found)
            |-> !r_used[r_gsi[GSI_W-1:0]])
        else $error("allocation picked a busy GSI");

    a_map_live_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_COMMIT && r_found
            && (r_cmd.op == OP_MAP_GSI || r_cmd.op == OP_MAP_LEGACY))
            |-> (TOT_W'(r_cidx) < r_total))
        else $error("mapping hit an unwritten controller slot");

    a_commit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_COMMIT && r_m_valid && !i_m_tready) |=> (r_state == BK_COMMIT))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/interrupt_route_allocator.sv =====
// Top level of the interrupt route allocator: front end, command queue, back end.
//
//  channel  dir  handshake              payload
//  s_       in   i_s_tvalid/o_s_tready  tdata 56 bits, tuser = action
//  m_       out  o_m_tvalid/i_m_tready  tdata 72 bits, tuser = status
//
// Steps per transaction in the back end, from queue head to result register:
//   free, add override, add controller, bad source, unknown action: commit
//   allocate: 32-bit-per-cycle bitmap scan, then commit
//   map gsi, map legacy: override lookup, range compare, pick, commit
// Reset (i_rst_n low, synchronous) clears the bitmap, restores the identity
// override table and empties the controller table.
// Input is taken while the two-entry queue has room; a stalled result holds
// the back end in its commit step, and the front end keeps accepting until
// the queue fills.
`default_nettype none
module interrupt_route_allocator #(
    parameter int GSI_SLOTS  = ira_pkg::GSI_SLOTS_DEF,
    parameter int CTRL_SLOTS = ira_pkg::CTRL_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // gsi[7:0] source_irq[15:8] override_flags[19:16] range_base[27:20]
    // range_count[36:28] dest_id[44:37] act_low[45] level_trigger[46]
    // vector[54:47], zero fill above
    input  wire logic [ira_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action[2:0]
    input  wire logic [ira_pkg::TUSER_W-1:0]   i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // gsi_out[7:0] controller[10:8] reg_select[20:11] entry_low[36:21]
    // entry_high[68:37], zero fill above
    output logic [ira_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // status[2:0]
    output logic [ira_pkg::TUSER_W-1:0]        o_m_tuser
);
    import ira_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_result res;

    ira_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    ira_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    ira_back #(
        .GSI_SLOTS  (GSI_SLOTS),
        .CTRL_SLOTS (CTRL_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (head_cmd),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

    // result fields packed from the lowest bit up
    assign o_m_tdata = {3'b0, res.entry_high, res.entry_low, res.reg_select,
                        res.controller, res.gsi_out};
    assign o_m_tuser = res.status;

endmodule
`default_nettype wire

// ===== verif/interrupt_route_allocator_tb.sv =====
// Self-checking testbench of the interrupt route allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module interrupt_route_allocator_tb;
    import ira_pkg::*;

    localparam int GSI_SLOTS   = GSI_SLOTS_DEF;
    localparam int CTRL_SLOTS  = CTRL_SLOTS_DEF;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 20;

    // one request as it travels on the slave side
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] gsi;
        logic [7:0] src;
        logic [3:0] flags;
        logic [7:0] base;
        logic [8:0] count;
        logic [7:0] lapic;
        logic       pol;
        logic       trig;
        logic [7:0] vec;
    } t_req;

    // directed row: request plus an optional hand-written result
    typedef struct {
        t_req    rq;
        bit      fixed;
        t_result res;
    } t_stim_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [TUSER_W-1:0]   i_s_tuser  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [TUSER_W-1:0]   o_m_tuser;

    interrupt_route_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Routing state as the testbench expects it to be
    // ------------------------------------------------------------------
    logic       gsi_taken  [GSI_SLOTS];
    logic [7:0] ovr_target [LEGACY_LINES];
    logic [3:0] ovr_mode   [LEGACY_LINES];
    int         ctl_base   [CTRL_SLOTS];
    int         ctl_pins   [CTRL_SLOTS];
    int         ctl_count;

    t_result    route_expect_q [$];
    t_stim_row  stim_rows [$];

    int tx_idle_pct  = 0;   // chance per cycle that the sender holds off
    int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    int err_count    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int status_seen  [8];
    int quiet_cycles = 0;

    function automatic void init_route_state();
        foreach (gsi_taken[i]) gsi_taken[i] = 1'b0;
        for (int i = 0; i < LEGACY_LINES; i++) begin
            ovr_target[i] = 8'(i);   // identity mapping out of reset
            ovr_mode[i]   = 4'h0;
        end
        foreach (ctl_base[i]) begin
            ctl_base[i] = 0;
            ctl_pins[i] = 0;
        end
        ctl_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // First controller whose range covers g wins; no hit gives no-controller.
    function automatic t_result resolve_mapping(logic [7:0] g, logic [7:0] lapic,
                                                logic pol, logic trig, logic [7:0] vec);
        t_result    r;
        logic [7:0] pin;
        r         = '0;
        r.status  = STS_NO_CTRL;
        r.gsi_out = g;
        for (int i = 0; i < ctl_count && i < CTRL_SLOTS; i++) begin
            if (int'(g) >= ctl_base[i] && int'(g) < ctl_base[i] + ctl_pins[i]) begin
                pin          = 8'(int'(g) - ctl_base[i]);
                r.status     = STS_OK;
                r.controller = 3'(i);
                r.reg_select = REG_SEL_BASE + {1'b0, pin, 1'b0};
                // fixed delivery, physical, unmasked: only vector/pol/trig set
                r.entry_low  = {trig, 1'b0, pol, 5'b0, vec};
                r.entry_high = {lapic, 24'h0};
                break;
            end
        end
        return r;
    endfunction

    // Apply one request to the expected state and return its result.
    function automatic t_result predict_route(t_req rq);
        t_result    r;
        logic       pol;
        logic       trig;
        logic [7:0] g;
        logic [3:0] m;
        r    = '0;
        pol  = rq.pol;
        trig = rq.trig;
        case (rq.action)
            ACT_ALLOC: begin
                r.status = STS_NO_FREE;
                for (int i = 0; i < GSI_SLOTS; i++) begin
                    if (!gsi_taken[i]) begin
                        gsi_taken[i] = 1'b1;
                        r.status     = STS_OK;
                        r.gsi_out    = 8'(i);
                        break;
                    end
                end
            end
            ACT_FREE: begin
                if (int'(rq.gsi) < GSI_SLOTS) gsi_taken[rq.gsi] = 1'b0;
                r.gsi_out = rq.gsi;
            end
            ACT_ADD_OVR: begin
                if (rq.src >= LEGACY_LINES) begin
                    r.status = STS_BAD_SRC;
                end else begin
                    ovr_target[rq.src[LEG_W-1:0]] = rq.gsi;
                    ovr_mode[rq.src[LEG_W-1:0]]   = rq.flags;
                    if (int'(rq.gsi) < GSI_SLOTS) gsi_taken[rq.gsi] = 1'b1;
                    r.gsi_out = rq.gsi;
                end
            end
            ACT_ADD_CTRL: begin
                if (ctl_count >= CTRL_SLOTS) begin
                    r.status = STS_FULL;
                end else begin
                    ctl_base[ctl_count] = int'(rq.base);
                    ctl_pins[ctl_count] = int'(rq.count);
                    r.controller        = 3'(ctl_count);
                    ctl_count++;
                end
            end
            ACT_MAP_GSI: begin
                r = resolve_mapping(rq.gsi, rq.lapic, pol, trig, rq.vec);
            end
            ACT_MAP_LEGACY: begin
                g = rq.src;
                if (rq.src < LEGACY_LINES) begin
                    // override codes 0 and 2 leave the request's fallback alone
                    m = ovr_mode[rq.src[LEG_W-1:0]];
                    if (m[1:0] == POL_ACT_LOW)       pol = 1'b1;
                    else if (m[1:0] == POL_ACT_HIGH) pol = 1'b0;
                    if (m[3:2] == TRIG_EDGE)         trig = 1'b0;
                    else if (m[3:2] == TRIG_LEVEL)   trig = 1'b1;
                    g = ovr_target[rq.src[LEG_W-1:0]];
                end
                r = resolve_mapping(g, rq.lapic, pol, trig, rq.vec);
            end
            default: r = '0;   // unknown action: no effect, all-zero result
        endcase
        return r;
    endfunction

    function automatic t_req req(logic [2:0] act, logic [7:0] g, logic [7:0] s,
                                 logic [3:0] f, logic [7:0] b, logic [8:0] c,
                                 logic [7:0] la, logic p, logic t, logic [7:0] v);
        t_req r;
        r = '{act, g, s, f, b, c, la, p, t, v};
        return r;
    endfunction

    function automatic t_result res(t_status st, logic [7:0] g, logic [2:0] c,
                                    logic [9:0] rs, logic [15:0] lo, logic [31:0] hi);
        t_result r;
        r = '{st, g, c, rs, lo, hi};
        return r;
    endfunction

    function automatic void add_row(t_req rq, bit fixed, t_result r);
        t_stim_row row;
        row.rq    = rq;
        row.fixed = fixed;
        row.res   = r;
        stim_rows.push_back(row);
    endfunction

    // Random request: every field noise first, then the fields that matter
    // for the chosen action steered toward interesting values.
    function automatic t_req random_req(bit alloc_only);
        t_req rq;
        int   roll;
        int   j;
        rq   = req(3'd0, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                   9'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        roll = $urandom_range(0, 99);
        if (alloc_only || roll < 15) begin
            rq.action = ACT_ALLOC;
        end else if (roll < 27) begin
            rq.action = ACT_FREE;
            // low GSIs are the ones most likely handed out
            if ($urandom_range(0, 99) < 60) rq.gsi = 8'($urandom_range(0, 40));
        end else if (roll < 42) begin
            rq.action = ACT_ADD_OVR;
            if ($urandom_range(0, 99) < 80) rq.src = 8'($urandom_range(0, LEGACY_LINES - 1));
        end else if (roll < 50) begin
            rq.action = ACT_ADD_CTRL;
            j = $urandom_range(0, 99);
            if (j < 70)      rq.count = 9'($urandom_range(1, 24));
            else if (j < 75) rq.count = 9'd0;
            else if (j < 80) rq.count = 9'd256;
            else if (j < 85) rq.count = 9'd511;
        end else if (roll < 72) begin
            rq.action = ACT_MAP_GSI;
            // once a controller exists, half the maps aim at or just above its base
            if (ctl_count > 0 && $urandom_range(0, 1)) begin
                j      = $urandom_range(0, ctl_count - 1);
                rq.gsi = 8'(ctl_base[j] + $urandom_range(0, 7));
            end
        end else if (roll < 95) begin
            rq.action = ACT_MAP_LEGACY;
            if ($urandom_range(0, 99) < 85) rq.src = 8'($urandom_range(0, LEGACY_LINES - 1));
        end else begin
            rq.action = 3'($urandom_range(6, 7));
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Slave side driver: one transaction per call, optional hold-off
    // ------------------------------------------------------------------
    task automatic send_item(t_req rq, bit fixed, t_result fx);
        t_result pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, rq.vec, rq.trig, rq.pol, rq.lapic, rq.count,
                       rq.base, rq.flags, rq.src, rq.gsi};
        i_s_tuser  <= rq.action;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        // accepted at this edge: update expected state in transaction order
        pred = predict_route(rq);
        route_expect_q.push_back(fixed ? fx : pred);
        items_sent++;
    endtask

    task automatic run_mixed(int n, bit alloc_only);
        repeat (n) send_item(random_req(alloc_only), 1'b0, '0);
    endtask

    // hold the sender off until every outstanding result has arrived
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (route_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Master side: random backpressure and result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                 $realtime, results_seen, what, got, want);
        err_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (route_expect_q.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_m_tdata[31:0], '0);
            end else begin
                want = route_expect_q.pop_front();
                check_field("status",     32'(o_m_tuser),        32'(want.status));
                check_field("gsi_out",    32'(o_m_tdata[7:0]),   32'(want.gsi_out));
                check_field("controller", 32'(o_m_tdata[10:8]),  32'(want.controller));
                check_field("reg_select", 32'(o_m_tdata[20:11]), 32'(want.reg_select));
                check_field("entry_low",  32'(o_m_tdata[36:21]), 32'(want.entry_low));
                check_field("entry_high", o_m_tdata[68:37],      want.entry_high);
                check_field("zero fill",  32'(o_m_tdata[71:69]), '0);
            end
            status_seen[o_m_tuser]++;
            results_seen++;
        end
    end

    // watchdog: any accepted transaction on either side resets the count
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, route_expect_q.size());
            $display("interrupt_route_allocator_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        init_route_state();

        // Directed table. Rows built on top of each other: the controller
        // ranges set up here (empty, 255 only, 16..31) are what later maps hit.
        // allocate hands out the lowest free GSI, free reopens it
        add_row(req(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(STS_OK, 0, 0, 0, 0, 0));
        add_row(req(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(STS_OK, 1, 0, 0, 0, 0));
        add_row(req(ACT_FREE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(STS_OK, 0, 0, 0, 0, 0));
        add_row(req(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(STS_OK, 0, 0, 0, 0, 0));
        add_row(req(ACT_FREE, 255, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(STS_OK, 255, 0, 0, 0, 0));
        // no controller yet
        add_row(req(ACT_MAP_GSI, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(STS_NO_CTRL, 0, 0, 0, 0, 0));
        add_row(req(ACT_MAP_LEGACY, 0, 5, 0, 0, 0, 0, 0, 0, 0), 1,
                res(STS_NO_CTRL, 5, 0, 0, 0, 0));
        // override source outside the legacy lines
        add_row(req(ACT_ADD_OVR, 3, 16, 15, 0, 0, 0, 0, 0, 0), 1,
                res(STS_BAD_SRC, 0, 0, 0, 0, 0));
        add_row(req(ACT_ADD_OVR, 255, 255, 15, 0, 0, 0, 0, 0, 0), 1,
                res(STS_BAD_SRC, 0, 0, 0, 0, 0));
        // zero pin count: stored, but covers nothing
        add_row(req(ACT_ADD_CTRL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res(STS_OK, 0, 0, 0, 0, 0));
        add_row(req(ACT_MAP_GSI, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(STS_NO_CTRL, 0, 0, 0, 0, 0));
        // top base with the largest pin count
        add_row(req(ACT_ADD_CTRL, 0, 0, 0, 255, 511, 0, 0, 0, 0), 1,
                res(STS_OK, 0, 1, 0, 0, 0));
        add_row(req(ACT_MAP_GSI, 255, 0, 0, 0, 0, 255, 1, 1, 255), 0, '0);
        add_row(req(ACT_ADD_CTRL, 0, 0, 0, 16, 16, 0, 0, 0, 0), 1,
                res(STS_OK, 0, 2, 0, 0, 0));
        add_row(req(ACT_MAP_GSI, 31, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        // overrides: forced low/level, forced high/edge, codes 2/2 keep fallbacks
        add_row(req(ACT_ADD_OVR, 20, 0, 4'b1111, 0, 0, 0, 0, 0, 0), 1,
                res(STS_OK, 20, 0, 0, 0, 0));
        add_row(req(ACT_MAP_LEGACY, 0, 0, 0, 0, 0, 1, 0, 0, 8'h30), 0, '0);
        add_row(req(ACT_ADD_OVR, 17, 15, 4'b0101, 0, 0, 0, 0, 0, 0), 1,
                res(STS_OK, 17, 0, 0, 0, 0));
        add_row(req(ACT_MAP_LEGACY, 0, 15, 0, 0, 0, 2, 1, 1, 8'h41), 0, '0);
        add_row(req(ACT_ADD_OVR, 18, 1, 4'b1010, 0, 0, 0, 0, 0, 0), 1,
                res(STS_OK, 18, 0, 0, 0, 0));
        add_row(req(ACT_MAP_LEGACY, 0, 1, 0, 0, 0, 3, 1, 0, 8'h22), 0, '0);
        // legacy source above the lines is used as the GSI itself
        add_row(req(ACT_MAP_LEGACY, 0, 200, 0, 0, 0, 8'h80, 0, 1, 8'h99), 1,
                res(STS_NO_CTRL, 200, 0, 0, 0, 0));
        // unknown actions with every field bit set
        add_row(req(3'd6, 255, 255, 15, 255, 511, 255, 1, 1, 255), 1,
                res(STS_OK, 0, 0, 0, 0, 0));
        add_row(req(3'd7, 255, 255, 15, 255, 511, 255, 1, 1, 255), 1,
                res(STS_OK, 0, 0, 0, 0, 0));
        // overrides reserved 17, 18, 20; lowest free is predicted
        add_row(req(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) send_item(stim_rows[k].rq, stim_rows[k].fixed, stim_rows[k].res);
        drain_results();

        // no idling on either side
        run_mixed(110, 1'b0);
        // sender idles about half the cycles
        tx_idle_pct = 49;
        run_mixed(110, 1'b0);
        // receiver stalls about half the cycles; an allocate burst longer than
        // the bitmap guarantees the no-free case, then a full pause
        tx_idle_pct  = 0;
        rx_stall_pct = 49;
        run_mixed(GSI_SLOTS + 4, 1'b1);
        drain_results();
        run_mixed(110, 1'b0);
        // both sides idle now and then
        tx_idle_pct  = 18;
        rx_stall_pct = 18;
        run_mixed(110, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (route_expect_q.size() != 0)
            report_mismatch("results never delivered", route_expect_q.size(), '0);

        $display("covered %0d transactions (%0d directed), %0d results checked",
                 items_sent, stim_rows.size(), results_seen);
        $display("status seen: no-free %0d, no-controller %0d, table-full %0d, bad-source %0d",
                 status_seen[STS_NO_FREE], status_seen[STS_NO_CTRL],
                 status_seen[STS_FULL], status_seen[STS_BAD_SRC]);
        if (err_count == 0) begin
            $display("interrupt_route_allocator_tb: PASS");
        end else begin
            $display("interrupt_route_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== interrupt_route_allocator.f =====
rtl/ira_pkg.sv
rtl/ira_front.sv
rtl/ira_queue.sv
rtl/ira_back.sv
rtl/interrupt_route_allocator.sv
verif/interrupt_route_allocator_tb.sv
